[sv/multichannel_moving_median_assert.svh]
// Assertion macros shared by the moving median RTL.
`ifndef MULTICHANNEL_MOVING_MEDIAN_ASSERT_SVH
`define MULTICHANNEL_MOVING_MEDIAN_ASSERT_SVH

// Check prop at every rising edge, skipped while reset is held.
`define MMM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("moving median check failed");

// Check prop at every rising edge, reset included.
`define MMM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("moving median check failed");

`endif

[sv/mmm_pkg.sv]
`timescale 1ns / 1ps

package mmm_pkg;

    localparam int CHANNELS    = 4;
    localparam int MAX_WINDOW  = 11;
    localparam int SAMPLE_BITS = 16;

    // Fixed field widths.
    localparam int CH_W  = 3;
    localparam int LEN_W = 4;
    localparam int PTR_W = 4;

    // Channel index into per-channel tables; the field never exceeds CH_W bits.
    localparam int CH_IDX_W = (CHANNELS <= 2) ? 1 :
                              (($clog2(CHANNELS) > CH_W) ? CH_W : $clog2(CHANNELS));

    // Window memory: CHANNELS rows of MAX_WINDOW entries.
    localparam int MEM_DEPTH = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W    = (MEM_DEPTH <= 2) ? 1 : $clog2(MEM_DEPTH);

    // Sort slots: the longest accepted window is MAX_WINDOW-1 entries.
    localparam int SLOT_CNT = MAX_WINDOW - 1;
    localparam int SLOT_W   = (SLOT_CNT <= 2) ? 1 : $clog2(SLOT_CNT);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

endpackage

[sv/multichannel_moving_median.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_stall    i_channel, i_window_len, i_sample
// out       from block o_out_valid / i_out_stall  o_median, o_error
//
// A valid item passes from its transfer through S_RUN, where the window memory
// delivers one entry per cycle to the sorter, and S_DONE to the output register;
// a rejected item skips S_RUN and goes from S_IDLE straight to S_DONE.
// Reset is synchronous and active low; it clears the write pointers and the
// per-entry valid bits, so unwritten window entries read as zero.
// The output register lets the next item enter while a result is stalled.

`include "multichannel_moving_median_assert.svh"

module multichannel_moving_median
    import mmm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CH_W-1:0]         i_channel,
    input  logic [LEN_W-1:0]        i_window_len,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_median,
    output logic                    o_error
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state;

    // Item context.
    logic [LEN_W-1:0]    r_len;
    logic                r_err;
    logic [CH_IDX_W-1:0] r_ch_idx;
    logic [ADDR_W-1:0]   r_base;

    // Per-channel write pointers and per-entry valid bits.
    logic [PTR_W-1:0]    r_wptr [CHANNELS];
    logic [MEM_DEPTH-1:0] r_ent_vld;

    // Window memory with registered read.
    t_sample             mem [MEM_DEPTH];
    t_sample             r_rd_data;
    logic                r_rd_ent_vld;
    logic                r_rd_pend;

    // Read issue and insertion counters.
    logic [LEN_W-1:0]    r_rd_idx;
    logic [LEN_W-1:0]    r_ins_cnt;

    // Sorted window, ascending.
    t_sample             r_sorted [SLOT_CNT];
    t_sample             n_sorted [SLOT_CNT];

    // Output register.
    logic                r_out_valid;
    t_sample             r_out_median;
    logic                r_out_error;

    // Input decode.
    logic                in_xfer;
    logic                in_bad;
    logic [CH_IDX_W-1:0] in_ch_idx;
    logic [PTR_W-1:0]    n_ptr;
    logic [ADDR_W-1:0]   in_base;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_issue;
    t_sample             rd_value;
    logic                out_free;
    logic [SLOT_CNT-1:0] keep;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;

    // Reject bad channel, zero length and over-long windows.
    assign in_bad = (32'(i_channel) >= CHANNELS) || (i_window_len == '0) ||
                    (32'(i_window_len) >= MAX_WINDOW);

    assign in_ch_idx = i_channel[CH_IDX_W-1:0];

    // Advance the pointer, wrap to zero once it reaches the window length.
    always_comb begin
        n_ptr = r_wptr[in_ch_idx] + PTR_W'(1);
        if (n_ptr >= i_window_len) begin
            n_ptr = '0;
        end
    end

    assign in_base = ADDR_W'(in_ch_idx) * ADDR_W'(MAX_WINDOW);
    assign wr_addr = in_base + ADDR_W'(n_ptr);
    assign wr_en   = in_xfer && !in_bad;

    // Issue one window read per cycle until the whole window is requested.
    assign rd_issue = (r_state == S_RUN) && (r_rd_idx < r_len);
    assign rd_addr  = r_base + ADDR_W'(r_rd_idx);

    // Entries never written since reset read as zero.
    assign rd_value = r_rd_ent_vld ? r_rd_data : '0;

    // Insertion into the sorted slots: slots at or below the new value hold,
    // the first larger slot takes the new value, the rest shift up by one.
    always_comb begin
        for (int i = 0; i < SLOT_CNT; i++) begin
            keep[i] = (LEN_W'(i) < r_ins_cnt) && (r_sorted[i] <= rd_value);
        end
        n_sorted[0] = keep[0] ? r_sorted[0] : rd_value;
        for (int i = 1; i < SLOT_CNT; i++) begin
            if (keep[i]) begin
                n_sorted[i] = r_sorted[i];
            end else if (keep[i-1]) begin
                n_sorted[i] = rd_value;
            end else begin
                n_sorted[i] = r_sorted[i-1];
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Window memory: write the new sample on a valid transfer, read one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_sample;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ent_vld   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_idx    <= '0;
            r_ins_cnt   <= '0;
            r_err       <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wptr[c] <= '0;
            end
        end else begin
            r_rd_pend    <= rd_issue;
            r_rd_ent_vld <= r_ent_vld[rd_addr];

            // Drop the result once the consumer takes it, unless a new one loads.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_len     <= i_window_len;
                        r_err     <= in_bad;
                        r_ch_idx  <= in_ch_idx;
                        r_base    <= in_base;
                        r_rd_idx  <= '0;
                        r_ins_cnt <= '0;
                        if (in_bad) begin
                            r_state <= S_DONE;
                        end else begin
                            r_wptr[in_ch_idx]  <= n_ptr;
                            r_ent_vld[wr_addr] <= 1'b1;
                            r_state            <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (rd_issue) begin
                        r_rd_idx <= r_rd_idx + LEN_W'(1);
                    end
                    if (r_rd_pend) begin
                        r_sorted  <= n_sorted;
                        r_ins_cnt <= r_ins_cnt + LEN_W'(1);
                    end else if (r_ins_cnt == r_len) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold the result until the output register is free.
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_error  <= r_err;
                        r_out_median <= r_err ? '0 : r_sorted[SLOT_W'(r_len >> 1)];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_out_median;
    assign o_error     = r_out_error;

    // Never insert more entries than the window holds.
    `MMM_ASSERT(a_ins_bound, i_clk, i_rst_n, (r_state == S_RUN) |-> (r_ins_cnt <= r_len))
    // Memory read data only arrives while a window is being sorted.
    `MMM_ASSERT(a_pend_in_run, i_clk, i_rst_n, r_rd_pend |-> (r_state == S_RUN))
    // A rejected item always reports a zero median.
    `MMM_ASSERT(a_err_zero, i_clk, i_rst_n, (r_out_valid && r_out_error) |-> (r_out_median == '0))
    // The advanced pointer always lands inside the new window.
    `MMM_ASSERT(a_ptr_in_win, i_clk, i_rst_n,
        (in_xfer && !in_bad) |=> (r_wptr[r_ch_idx] < r_len))

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
    import mmm_pkg::*;
();

    // Longest stretch with no transfer on either channel before the run is called hung.
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1380;
    localparam int DRAIN_EVERY   = 350;
    localparam int HOLDOFF_LEN   = 200;
    localparam int TAIL_CYCLES   = 40;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [LEN_W-1:0] window_len;
        t_sample          sample;
        bit               drain_first;
    } t_sample_item;

    typedef struct packed {
        t_sample median;
        logic    error;
    } t_median_result;

    logic             i_clk        = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid   = 1'b0;
    logic             o_in_stall;
    logic [CH_W-1:0]  i_channel    = '0;
    logic [LEN_W-1:0] i_window_len = '0;
    t_sample          i_sample     = '0;
    logic             o_out_valid;
    logic             i_out_stall  = 1'b0;
    t_sample          o_median;
    logic             o_error;

    multichannel_moving_median DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_channel    (i_channel),
        .i_window_len (i_window_len),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_median     (o_median),
        .o_error      (o_error)
    );

    // Shadow copy of the per-channel windows and write pointers.
    t_sample          win_shadow [CHANNELS][MAX_WINDOW] = '{default: '0};
    logic [PTR_W-1:0] ptr_shadow [CHANNELS] = '{default: '0};

    t_sample_item   sample_q[$];
    t_median_result median_expected_q[$];

    int  err_count    = 0;
    int  results_seen = 0;
    int  idle_cycles  = 0;
    bit  in_took      = 0;

    // Sender pacing.
    int  send_gap     = 0;
    int  send_burst   = 0;

    // Receiver pacing and forced hold-off.
    int  recv_stall   = 0;
    int  recv_quiet   = 0;
    int  holdoff_left = 0;
    int  holdoff_mark = 400;
    int  holdoff_done = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the shadow state for one accepted transfer and work out its result.
    function automatic void median_predict(input logic [CH_W-1:0] ch,
                                           input logic [LEN_W-1:0] len,
                                           input t_sample smp,
                                           output t_median_result res);
        t_sample             ranked [MAX_WINDOW];
        t_sample             v;
        logic [PTR_W-1:0]    p;
        logic [CH_IDX_W-1:0] ci;
        int                  i;
        int                  j;
        res.median = '0;
        res.error  = 1'b1;
        // Rejected items leave the state untouched.
        if (ch >= CHANNELS || len >= MAX_WINDOW || len == 0)
            return;
        ci = ch[CH_IDX_W-1:0];
        // The pointer keeps its old value across a length change, then wraps.
        p = ptr_shadow[ci] + 1'b1;
        if (p >= len)
            p = '0;
        ptr_shadow[ci] = p;
        win_shadow[ci][p] = smp;
        for (i = 0; i < len; i++) begin
            v = win_shadow[ci][i];
            j = i;
            while (j > 0 && ranked[j-1] > v) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = v;
        end
        res.median = ranked[len/2];
        res.error  = 1'b0;
    endfunction

    // Mostly short gaps, a few long ones, and stretches with none at all.
    function automatic int pick_gap(inout int burst);
        int r;
        r = $urandom_range(99);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if (r < 2) begin
            burst = $urandom_range(80, 30);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic push_item(input int ch, input int len, input int smp, input bit drain);
        t_sample_item it;
        it.channel     = ch[CH_W-1:0];
        it.window_len  = len[LEN_W-1:0];
        it.sample      = smp[SAMPLE_BITS-1:0];
        it.drain_first = drain;
        sample_q.push_back(it);
    endtask

    // Driver: present the next item at the falling edge once the last one transferred.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap--;
            end else if (sample_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (sample_q[0].drain_first && median_expected_q.size() != 0) begin
                // Hold the sender until every outstanding result has come back.
                i_in_valid <= 1'b0;
            end else begin
                i_channel    <= sample_q[0].channel;
                i_window_len <= sample_q[0].window_len;
                i_sample     <= sample_q[0].sample;
                i_in_valid   <= 1'b1;
                void'(sample_q.pop_front());
                send_gap = pick_gap(send_burst);
            end
        end
    end

    // Receiver: random stalls, plus a long forced hold-off at a couple of points
    // so the block backs up and stalls its input.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (holdoff_left == 0 && holdoff_done < 2 && results_seen >= holdoff_mark) begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_mark = holdoff_mark + 600;
                holdoff_done++;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_stall <= 1'b1;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_out_stall <= 1'b1;
            end else begin
                recv_stall = pick_gap(recv_quiet);
                if (recv_stall > 0) begin
                    recv_stall--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge i_clk) begin
        t_median_result exp_res;
        t_median_result new_res;
        bit             moved;
        moved = 1'b0;
        if (i_rst_n) begin
            in_took <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                median_predict(i_channel, i_window_len, i_sample, new_res);
                median_expected_q.push_back(new_res);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                results_seen++;
                if (median_expected_q.size() == 0) begin
                    $error("unexpected result: median %0d error %0b", o_median, o_error);
                    err_count++;
                end else begin
                    exp_res = median_expected_q.pop_front();
                    if (o_median !== exp_res.median) begin
                        $error("median: expected %0d, got %0d", exp_res.median, o_median);
                        err_count++;
                    end
                    if (o_error !== exp_res.error) begin
                        $error("error: expected %0b, got %0b", exp_res.error, o_error);
                        err_count++;
                    end
                end
            end
            // Watchdog: count cycles with no transfer on either side.
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int               n;
        int               ch;
        int               len;
        int               smp;
        int               r;
        int               cur_len [CHANNELS];
        int               c;

        i_rst_n      = 1'b0;
        for (c = 0; c < CHANNELS; c++) begin
            cur_len[c]    = $urandom_range(MAX_WINDOW - 1, 1);
        end

        // Directed part. Fresh channel at the longest window: unwritten entries rank as zero.
        push_item(0, MAX_WINDOW - 1, 32767, 0);
        push_item(0, MAX_WINDOW - 1, -32768, 0);
        push_item(0, MAX_WINDOW - 1, -32768, 0);
        // Shrink the window: the pointer wraps from its old position.
        push_item(0, 1, 5, 0);
        push_item(0, 2, -1, 0);
        push_item(0, 3, 7, 0);
        // Grow it again.
        push_item(0, MAX_WINDOW - 1, 100, 0);
        // Bad channels.
        push_item(CHANNELS, 3, 1234, 0);
        push_item(7, 5, -1234, 0);
        // Window too long, at the boundary and at the field's top.
        push_item(1, MAX_WINDOW, 42, 0);
        push_item(3, 15, -42, 0);
        // Zero window length.
        push_item(2, 0, 99, 0);
        // Extremes on other channels.
        push_item(1, 1, -32768, 0);
        push_item(1, 1, 32767, 0);
        push_item(2, 2, 32767, 0);
        push_item(2, 2, -32768, 0);
        push_item(3, MAX_WINDOW - 1, -1, 0);
        push_item(3, MAX_WINDOW - 1, -1, 0);
        push_item(3, MAX_WINDOW - 1, 0, 0);
        push_item(3, MAX_WINDOW - 1, 32767, 0);
        push_item(CHANNELS - 1, 4, -32768, 0);

        // Random part: mostly well-formed runs per channel, some noise.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                ch  = $urandom_range(7);
                len = $urandom_range(15);
            end else begin
                ch = $urandom_range(CHANNELS - 1);
                if ($urandom_range(49) == 0)
                    cur_len[ch] = $urandom_range(MAX_WINDOW - 1, 1);
                len = cur_len[ch];
            end
            r = $urandom_range(99);
            if (r < 50)
                smp = $urandom_range(65535);
            else if (r < 80)
                smp = $urandom_range(8) - 4;
            else if (r < 90)
                smp = $urandom_range(200) - 100;
            else begin
                case ($urandom_range(3))
                    0:       smp = -32768;
                    1:       smp = 32767;
                    2:       smp = -1;
                    default: smp = 0;
                endcase
            end
            push_item(ch, len, smp, (n % DRAIN_EVERY) == 0);
        end

        // Hold reset, then release it at a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last transfer, then for every result, then let the tail settle.
        while (sample_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (median_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0 && median_expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/mmm_pkg.sv
sv/multichannel_moving_median.sv
dv/tb_top.sv
